>>> sv/sqvt_pkg.sv
// shared types, constants and sine helpers for the sprite quad vertex transform
package sqvt_pkg;

  localparam int unsigned S_TDATA_W  = 176;
  localparam int unsigned M_TDATA_W  = 64;
  localparam int unsigned M_TUSER_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned RECIP_W    = 31;
  localparam int unsigned DIV_A_W    = 30;

  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_W  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_H  = 2'd3;

  localparam logic [1:0] CORNER_BR = 2'd3;

  localparam logic [CFG_DATA_W-1:0] VIEWPORT_W_RST = 14'd1280;
  localparam logic [CFG_DATA_W-1:0] VIEWPORT_H_RST = 14'd720;
  localparam logic [CFG_DATA_W-1:0] TEXTURE_W_RST  = 14'd1;
  localparam logic [CFG_DATA_W-1:0] TEXTURE_H_RST  = 14'd1;

  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [RECIP_W-1:0] RECIP_VW_RST = RECIP_W'(ONE_Q30 / 64'd1280);
  localparam logic [RECIP_W-1:0] RECIP_VH_RST = RECIP_W'(ONE_Q30 / 64'd720);
  localparam logic [RECIP_W-1:0] RECIP_TW_RST = RECIP_W'(ONE_Q30);
  localparam logic [RECIP_W-1:0] RECIP_TH_RST = RECIP_W'(ONE_Q30);

  localparam longint unsigned TAYLOR_DIV [8] = '{64'd1, 64'd6, 64'd20, 64'd42,
                                                 64'd72, 64'd110, 64'd156, 64'd210};

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [12:0]        tex_pos_x;
    logic [12:0]        tex_pos_y;
    logic [12:0]        tex_size_x;
    logic [12:0]        tex_size_y;
    logic signed [17:0] pivot_x;
    logic signed [17:0] pivot_y;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } sprite_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] vw;
    logic [CFG_DATA_W-1:0] vh;
    logic [CFG_DATA_W-1:0] tw;
    logic [CFG_DATA_W-1:0] th;
    logic [RECIP_W-1:0]    rvw;
    logic [RECIP_W-1:0]    rvh;
    logic [RECIP_W-1:0]    rtw;
    logic [RECIP_W-1:0]    rth;
  } cfg_t;

  // sine of f/2^30 quarter turns in q30, taylor series
  function automatic longint sin_quarter(input longint unsigned f);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x    = (f * HALF_PI_Q30) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n];
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  // sine of a 32-bit turn fraction in q1.14
  function automatic logic signed [15:0] sin_q14(input longint unsigned ang);
    longint unsigned a;
    longint unsigned q;
    longint unsigned f;
    longint          v;
    longint          r;
    a = ang & 64'hFFFF_FFFF;
    q = a >> 30;
    f = a & (ONE_Q30 - 64'd1);
    if (q[0]) begin
      f = ONE_Q30 - f;
    end
    v = sin_quarter(f);
    if (v < 0) begin
      v = 0;
    end
    r = (v + 64'sd32768) >>> 16;
    if (r > 16384) begin
      r = 16384;
    end
    return q[1] ? -16'(r) : 16'(r);
  endfunction

endpackage

>>> sv/sqvt_recip.sv
// configuration registers and serial reciprocal unit for the size registers
module sqvt_recip (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sqvt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sqvt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output sqvt_pkg::cfg_t                      cfg_o,
  output logic                                busy_o
);

  sqvt_pkg::cfg_t cfg_q;
  logic                                busy_q;
  logic [4:0]                          cnt_q;
  logic [sqvt_pkg::CFG_DATA_W:0]       rem_q;
  logic [sqvt_pkg::RECIP_W-1:0]        quo_q;
  logic [sqvt_pkg::CFG_DATA_W-1:0]     dsor_q;
  logic [sqvt_pkg::CFG_IDX_W-1:0]      tgt_q;

  logic                                wr;
  logic [sqvt_pkg::CFG_DATA_W-1:0]     eff;
  logic [sqvt_pkg::CFG_DATA_W:0]       rem_sh;
  logic                                ge;
  logic [sqvt_pkg::CFG_DATA_W:0]       rem_d;
  logic [sqvt_pkg::RECIP_W-1:0]        quo_d;

  assign cfg_ready_o = !busy_q;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign eff         = (cfg_data_i == '0) ? sqvt_pkg::CFG_DATA_W'(1) : cfg_data_i;
  assign busy_o      = busy_q;
  assign cfg_o       = cfg_q;

  // restoring division of 2^30 by the register, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_q[sqvt_pkg::CFG_DATA_W-1:0], (cnt_q == 5'd30)};
    ge     = rem_sh >= {1'b0, dsor_q};
    rem_d  = ge ? (rem_sh - {1'b0, dsor_q}) : rem_sh;
    quo_d  = {quo_q[sqvt_pkg::RECIP_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vw  <= sqvt_pkg::VIEWPORT_W_RST;
      cfg_q.vh  <= sqvt_pkg::VIEWPORT_H_RST;
      cfg_q.tw  <= sqvt_pkg::TEXTURE_W_RST;
      cfg_q.th  <= sqvt_pkg::TEXTURE_H_RST;
      cfg_q.rvw <= sqvt_pkg::RECIP_VW_RST;
      cfg_q.rvh <= sqvt_pkg::RECIP_VH_RST;
      cfg_q.rtw <= sqvt_pkg::RECIP_TW_RST;
      cfg_q.rth <= sqvt_pkg::RECIP_TH_RST;
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      tgt_q     <= '0;
    end else if (wr) begin
      case (cfg_index_i)
        sqvt_pkg::REG_VIEWPORT_W: cfg_q.vw <= eff;
        sqvt_pkg::REG_VIEWPORT_H: cfg_q.vh <= eff;
        sqvt_pkg::REG_TEXTURE_W:  cfg_q.tw <= eff;
        sqvt_pkg::REG_TEXTURE_H:  cfg_q.th <= eff;
        default: ;
      endcase
      busy_q <= 1'b1;
      cnt_q  <= 5'd30;
      tgt_q  <= cfg_index_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        case (tgt_q)
          sqvt_pkg::REG_VIEWPORT_W: cfg_q.rvw <= quo_d;
          sqvt_pkg::REG_VIEWPORT_H: cfg_q.rvh <= quo_d;
          sqvt_pkg::REG_TEXTURE_W:  cfg_q.rtw <= quo_d;
          sqvt_pkg::REG_TEXTURE_H:  cfg_q.rth <= quo_d;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      dsor_q <= eff;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  ast_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |=> busy_q) else $error("write did not start reciprocal");

  ast_recip_vw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> ((64'(cfg_q.rvw) * 64'(cfg_q.vw) <= sqvt_pkg::ONE_Q30) &&
                 (64'(cfg_q.rvw) * 64'(cfg_q.vw) + 64'(cfg_q.vw) > sqvt_pkg::ONE_Q30)))
    else $error("viewport width reciprocal wrong");

endmodule

>>> sv/sqvt_front.sv
// sprite intake: field decode and sine/cosine rom lookup
module sqvt_front #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [sqvt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic                              busy_i,
  output sqvt_pkg::sprite_t                 spr_o,
  output logic                              spr_valid_o,
  input  logic                              spr_ready_i
);

  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned PROD_W = 16 + IDX_W + 1;

  typedef logic [31:0] sc_table_t [SINE_TABLE_DEPTH];

  function automatic sc_table_t build_sc_table();
    sc_table_t       t;
    longint unsigned ang;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      ang  = (longint'(i) << 32) / SINE_TABLE_DEPTH;
      t[i] = {sqvt_pkg::sin_q14(ang + sqvt_pkg::ONE_Q30), sqvt_pkg::sin_q14(ang)};
    end
    return t;
  endfunction

  localparam sc_table_t SC_TABLE = build_sc_table();

  sqvt_pkg::sprite_t spr_q;
  logic              valid_q;
  logic              accept;
  logic [PROD_W-1:0] rprod;
  logic [IDX_W-1:0]  idx;
  logic [31:0]       sc;

  assign s_axis_tready = !busy_i && (!valid_q || spr_ready_i);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rprod         = PROD_W'(s_axis_tdata[87:72]) * PROD_W'(SINE_TABLE_DEPTH);
  assign idx           = rprod[16 +: IDX_W];
  assign sc            = SC_TABLE[idx];
  assign spr_o         = spr_q;
  assign spr_valid_o   = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (spr_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      spr_q.pos_x      <= s_axis_tdata[19:0];
      spr_q.pos_y      <= s_axis_tdata[39:20];
      spr_q.scale_x    <= s_axis_tdata[55:40];
      spr_q.scale_y    <= s_axis_tdata[71:56];
      spr_q.tex_pos_x  <= s_axis_tdata[100:88];
      spr_q.tex_pos_y  <= s_axis_tdata[113:101];
      spr_q.tex_size_x <= s_axis_tdata[126:114];
      spr_q.tex_size_y <= s_axis_tdata[139:127];
      spr_q.pivot_x    <= s_axis_tdata[157:140];
      spr_q.pivot_y    <= s_axis_tdata[175:158];
      spr_q.sin_v      <= sc[15:0];
      spr_q.cos_v      <= sc[31:16];
    end
  end

endmodule

>>> sv/sqvt_fifo.sv
// two-entry sprite queue between intake and vertex pipeline
module sqvt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sqvt_pkg::sprite_t in_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output sqvt_pkg::sprite_t out_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);

  sqvt_pkg::sprite_t mem_q [2];
  logic [1:0]        count_q;
  logic              wr_q;
  logic              rd_q;
  logic              push;
  logic              pop;

  assign in_ready_o  = count_q != 2'd2;
  assign out_valid_o = count_q != 2'd0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_ready_i && out_valid_o;
  assign out_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_i;
    end
  end

  ast_no_overpop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> count_q != 2'd0) else $error("pop from empty sprite queue");

endmodule

>>> sv/sqvt_back.sv
// vertex pipeline: corner offsets, rotation, ndc and uv division, saturation
module sqvt_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sqvt_pkg::sprite_t                 spr_i,
  input  logic                              spr_valid_i,
  output logic                              spr_ready_o,
  input  sqvt_pkg::cfg_t                    cfg_i,
  output logic [sqvt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic [sqvt_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);

  localparam int unsigned AW = sqvt_pkg::DIV_A_W;

  logic       en;
  logic       issue;
  logic [1:0] k_q;
  logic [8:1] v_q;
  logic [1:0] ks_q [8:1];
  logic       out_valid_q;

  // per-lane divisor and reciprocal: x, y, u, v
  logic [sqvt_pkg::CFG_DATA_W-1:0] dv [4];
  logic [sqvt_pkg::RECIP_W-1:0]    rc [4];

  assign dv[0] = cfg_i.vw;
  assign dv[1] = cfg_i.vh;
  assign dv[2] = cfg_i.tw;
  assign dv[3] = cfg_i.th;
  assign rc[0] = cfg_i.rvw;
  assign rc[1] = cfg_i.rvh;
  assign rc[2] = cfg_i.rtw;
  assign rc[3] = cfg_i.rth;

  assign en          = !out_valid_q || m_axis_tready;
  assign issue       = en && spr_valid_i;
  assign spr_ready_o = issue && (k_q == sqvt_pkg::CORNER_BR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      if (issue) begin
        k_q <= k_q + 2'd1;
      end
      v_q         <= {v_q[7:1], issue};
      out_valid_q <= v_q[8];
    end
  end

  // stage 1
  logic [12:0]        cx;
  logic [12:0]        cy;
  logic [13:0]        tsx;
  logic [13:0]        tsy;
  logic signed [19:0] d1x_q, d1y_q;
  logic signed [15:0] sc1x_q, sc1y_q, s1_q, c1_q;
  logic signed [19:0] p1x_q, p1y_q;
  logic [AW-1:0]      au_q [4:1];
  logic [AW-1:0]      av_q [4:1];

  assign cx  = k_q[0] ? spr_i.tex_size_x : '0;
  assign cy  = k_q[1] ? spr_i.tex_size_y : '0;
  assign tsx = {1'b0, spr_i.tex_pos_x} + {1'b0, cx};
  assign tsy = {1'b0, spr_i.tex_pos_y} + {1'b0, cy};

  // stage 2..4
  logic signed [35:0] r2x_q, r2y_q;
  logic signed [15:0] s2_q, c2_q;
  logic signed [19:0] p2x_q, p2y_q, p3x_q, p3y_q;
  logic signed [51:0] m3_q [4];
  logic signed [51:0] sum4_q [2];

  // stage 5..8, lane arrays
  logic [AW-1:0]      a5_q [4];
  logic               n5_q [4];
  logic [AW-1:0]      q6_q [4];
  logic [AW-1:0]      a6_q [4];
  logic               n6_q [4];
  logic [43:0]        qw7_q [4];
  logic [AW-1:0]      q7_q [4];
  logic [AW-1:0]      a7_q [4];
  logic               n7_q [4];
  logic signed [31:0] val8_q [4];

  logic signed [38:0] nsh [2];
  logic signed [30:0] nc [2];
  logic [60:0]        prod [4];
  logic [AW:0]        rem8 [4];
  logic [AW-1:0]      qfix [4];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nsh[l] = 39'(sum4_q[l] >>> 13);
      if (nsh[l] > 39'sd1073741823) begin
        nc[l] = 31'sh3FFFFFFF;
      end else if (nsh[l] < -39'sd1073741824) begin
        nc[l] = 31'sh40000000;
      end else begin
        nc[l] = nsh[l][30:0];
      end
    end
    for (int l = 0; l < 4; l++) begin
      prod[l] = 61'(a5_q[l]) * 61'(rc[l]);
      rem8[l] = {1'b0, a7_q[l]} - {1'b0, qw7_q[l][AW-1:0]};
      qfix[l] = q7_q[l] + AW'(rem8[l] >= (AW+1)'(dv[l]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1x_q  <= $signed({3'b0, cx, 4'b0}) - 20'(spr_i.pivot_x);
      d1y_q  <= $signed({3'b0, cy, 4'b0}) - 20'(spr_i.pivot_y);
      sc1x_q <= spr_i.scale_x;
      sc1y_q <= spr_i.scale_y;
      s1_q   <= spr_i.sin_v;
      c1_q   <= spr_i.cos_v;
      p1x_q  <= spr_i.pos_x;
      p1y_q  <= spr_i.pos_y;
      au_q[1] <= AW'({tsx, 14'b0}) + AW'(cfg_i.tw >> 1);
      av_q[1] <= AW'({tsy, 14'b0}) + AW'(cfg_i.th >> 1);
      for (int i = 2; i <= 4; i++) begin
        au_q[i] <= au_q[i-1];
        av_q[i] <= av_q[i-1];
      end
      for (int i = 2; i <= 8; i++) begin
        ks_q[i] <= ks_q[i-1];
      end
      ks_q[1] <= k_q;

      r2x_q <= 36'(sc1x_q) * 36'(d1x_q);
      r2y_q <= 36'(sc1y_q) * 36'(d1y_q);
      s2_q  <= s1_q;
      c2_q  <= c1_q;
      p2x_q <= p1x_q;
      p2y_q <= p1y_q;

      m3_q[0] <= 52'(c2_q) * 52'(r2x_q);
      m3_q[1] <= 52'(s2_q) * 52'(r2y_q);
      m3_q[2] <= 52'(s2_q) * 52'(r2x_q);
      m3_q[3] <= 52'(c2_q) * 52'(r2y_q);
      p3x_q   <= p2x_q;
      p3y_q   <= p2y_q;

      sum4_q[0] <= m3_q[0] - m3_q[1] + (52'(p3x_q) <<< 22)
                   + $signed(52'({cfg_i.vw, 12'b0}));
      sum4_q[1] <= m3_q[2] + m3_q[3] + (52'(p3y_q) <<< 22)
                   + $signed(52'({cfg_i.vh, 12'b0}));

      for (int l = 0; l < 2; l++) begin
        a5_q[l] <= nc[l][30] ? ~nc[l][AW-1:0] : nc[l][AW-1:0];
        n5_q[l] <= nc[l][30];
      end
      a5_q[2] <= au_q[4];
      a5_q[3] <= av_q[4];
      n5_q[2] <= 1'b0;
      n5_q[3] <= 1'b0;

      for (int l = 0; l < 4; l++) begin
        q6_q[l]   <= prod[l][59:30];
        a6_q[l]   <= a5_q[l];
        n6_q[l]   <= n5_q[l];
        qw7_q[l]  <= 44'(q6_q[l]) * 44'(dv[l]);
        q7_q[l]   <= q6_q[l];
        a7_q[l]   <= a6_q[l];
        n7_q[l]   <= n6_q[l];
        val8_q[l] <= n7_q[l] ? ~{2'b0, qfix[l]} : {2'b0, qfix[l]};
      end
    end
  end

  // output register with saturation
  logic signed [31:0] tx, ty;
  logic [15:0]        ox, oy, ou, ov;
  logic               clip;
  logic [15:0]        ox_q, oy_q, ou_q, ov_q;
  logic               clip_q;
  logic [1:0]         corner_q;

  always_comb begin
    clip = 1'b0;
    tx   = val8_q[0] - 32'sd4096;
    ty   = 32'sd4096 - val8_q[1];
    if (tx > 32'sd32767) begin
      ox = 16'h7FFF; clip = 1'b1;
    end else if (tx < -32'sd32768) begin
      ox = 16'h8000; clip = 1'b1;
    end else begin
      ox = tx[15:0];
    end
    if (ty > 32'sd32767) begin
      oy = 16'h7FFF; clip = 1'b1;
    end else if (ty < -32'sd32768) begin
      oy = 16'h8000; clip = 1'b1;
    end else begin
      oy = ty[15:0];
    end
    if (val8_q[2] > 32'sd65535) begin
      ou = 16'hFFFF; clip = 1'b1;
    end else begin
      ou = val8_q[2][15:0];
    end
    if (val8_q[3] > 32'sd65535) begin
      ov = 16'hFFFF; clip = 1'b1;
    end else begin
      ov = val8_q[3][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q     <= ox;
      oy_q     <= oy;
      ou_q     <= ou;
      ov_q     <= ov;
      clip_q   <= clip;
      corner_q <= ks_q[8];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {ov_q, ou_q, oy_q, ox_q};
  assign m_axis_tuser  = {clip_q, corner_q};
  assign m_axis_tlast  = corner_q == sqvt_pkg::CORNER_BR;

  ast_div_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[7] |-> (rem8[0] < ((AW+1)'(dv[0]) << 1)))
    else $error("ndc quotient estimate off by more than one");

  ast_corner_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v_q[8] && ks_q[8] == sqvt_pkg::CORNER_BR && v_q[7]) |=> ks_q[8] == 2'd0)
    else $error("corner order broken");

endmodule

>>> sv/sprite_quad_vertex_transform.sv
// rotated sprite quad setup: one sprite in, four ndc/uv vertices out
// Each accepted sprite beat produces four vertex beats (top-left, top-right,
// bottom-left, bottom-right), one per cycle while m_axis_tready is high, so the
// output port limits the sprite rate. The path from input to first vertex runs
// through the rom lookup, the queue and the nine-stage vertex pipeline.
// The sine/cosine rom has SINE_TABLE_DEPTH entries and is built at elaboration.
// Divisions by the viewport and texture sizes use reciprocals; a write to a
// size register recomputes its reciprocal, during which neither sprites nor
// further writes are taken.
module sprite_quad_vertex_transform #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pos_x, pos_y, scale_x, scale_y, rotation, tex_pos_x, tex_pos_y,
  // tex_size_x, tex_size_y, pivot_x, pivot_y
  input  logic [sqvt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // ndc_x, ndc_y, tex_u, tex_v
  output logic [sqvt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // corner, clipped
  output logic [sqvt_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sqvt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sqvt_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  sqvt_pkg::cfg_t    cfg;
  logic              busy;
  sqvt_pkg::sprite_t f_spr;
  logic              f_valid;
  logic              f_ready;
  sqvt_pkg::sprite_t q_spr;
  logic              q_valid;
  logic              q_ready;

  sqvt_recip u_recip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .busy_o      (busy)
  );

  sqvt_front #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .busy_i        (busy),
    .spr_o         (f_spr),
    .spr_valid_o   (f_valid),
    .spr_ready_i   (f_ready)
  );

  sqvt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (f_spr),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .out_o       (q_spr),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready)
  );

  sqvt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .spr_i         (q_spr),
    .spr_valid_i   (q_valid),
    .spr_ready_o   (q_ready),
    .cfg_i         (cfg),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

endmodule

>>> dv/testbench.sv
// testbench for the sprite quad vertex transform: directed table, random sprites, config sweeps
`timescale 1ns / 100ps

module testbench;
  import sqvt_pkg::*;

  typedef struct packed {
    logic signed [17:0] pivot_y;
    logic signed [17:0] pivot_x;
    logic [12:0]        tex_size_y;
    logic [12:0]        tex_size_x;
    logic [12:0]        tex_pos_y;
    logic [12:0]        tex_pos_x;
    logic [15:0]        rotation;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_x;
  } sprite_beat_t;

  typedef struct {
    logic [1:0]  corner;
    logic [15:0] ndc_x;
    logic [15:0] ndc_y;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic        clipped;
    logic        last;
  } vertex_t;

  typedef struct {
    sprite_beat_t sp;
    bit           typed;
    logic [15:0]  ndc_x;
    logic [15:0]  ndc_y;
    logic [15:0]  tex_u;
    logic [15:0]  tex_v;
    logic         clipped;
  } sprite_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sprite_quad_vertex_transform u_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  longint      vp_w = 1280, vp_h = 720, tx_w = 1, tx_h = 1;
  vertex_t     pending_vertices[$];
  sprite_row_t sprite_table[$];
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          mismatches = 0, vertices_seen = 0, sprites_sent = 0, cfg_writes = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("timeout at %0t", $time);
    $display("Some tests failed");
    $finish;
  end

  // quarter-wave sine in q30, taylor series in fixed point
  function automatic longint quarter_sine(longint unsigned frac);
    longint unsigned x, term;
    longint          acc;
    x = (frac * 64'd1686629713) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    return acc;
  endfunction

  function automatic longint turn_sine(longint unsigned ang);
    longint unsigned quad, frac;
    longint          v, r;
    ang  = ang & 64'hFFFF_FFFF;
    quad = ang >> 30;
    frac = ang & ((64'd1 << 30) - 1);
    if (quad[0]) frac = (64'd1 << 30) - frac;
    v = quarter_sine(frac);
    if (v < 0) v = 0;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    return quad[1] ? -r : r;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi, ref logic flag);
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic void predict_vertices(sprite_beat_t sp);
    longint unsigned ang;
    longint sn, cs, cx, cy, rx, ry, px, qy, nx, ny, u, v, w, h, tw, th;
    vertex_t vx;
    w  = vp_w ? vp_w : 1;
    h  = vp_h ? vp_h : 1;
    tw = tx_w ? tx_w : 1;
    th = tx_h ? tx_h : 1;
    ang = longint'(sp.rotation >> 6) << 22;
    sn = turn_sine(ang);
    cs = turn_sine(ang + (64'd1 << 30));
    for (int k = 0; k < 4; k++) begin
      cx = k[0] ? longint'(sp.tex_size_x) : 0;
      cy = k[1] ? longint'(sp.tex_size_y) : 0;
      rx = longint'(sp.scale_x) * (cx * 16 - longint'(sp.pivot_x));
      ry = longint'(sp.scale_y) * (cy * 16 - longint'(sp.pivot_y));
      px = cs * rx - sn * ry + longint'(sp.pos_x) * (64'sd1 <<< 22);
      qy = sn * rx + cs * ry + longint'(sp.pos_y) * (64'sd1 <<< 22);
      nx = floor_quot(px + w * 4096, w * 8192) - 4096;
      ny = 4096 - floor_quot(qy + h * 4096, h * 8192);
      u  = (((longint'(sp.tex_pos_x) + cx) << 14) + tw / 2) / tw;
      v  = (((longint'(sp.tex_pos_y) + cy) << 14) + th / 2) / th;
      vx.clipped = 1'b0;
      vx.corner  = k[1:0];
      vx.ndc_x   = 16'(sat(nx, -32768, 32767, vx.clipped));
      vx.ndc_y   = 16'(sat(ny, -32768, 32767, vx.clipped));
      vx.tex_u   = 16'(sat(u, 0, 65535, vx.clipped));
      vx.tex_v   = 16'(sat(v, 0, 65535, vx.clipped));
      vx.last    = (k[1:0] == CORNER_BR);
      pending_vertices.push_back(vx);
    end
  endfunction

  function automatic sprite_beat_t mk_sprite(int px, int py, int sx, int sy, int rot,
                                             int tpx, int tpy, int tsx, int tsy,
                                             int pvx, int pvy);
    sprite_beat_t sp;
    sp.pos_x = px; sp.pos_y = py; sp.scale_x = sx; sp.scale_y = sy;
    sp.rotation = rot; sp.tex_pos_x = tpx; sp.tex_pos_y = tpy;
    sp.tex_size_x = tsx; sp.tex_size_y = tsy; sp.pivot_x = pvx; sp.pivot_y = pvy;
    return sp;
  endfunction

  function automatic void add_row(sprite_beat_t sp, bit typed = 0, int nx = 0, int ny = 0,
                                  int u = 0, int v = 0, bit clip = 0);
    sprite_row_t r;
    r.sp = sp; r.typed = typed;
    r.ndc_x = nx; r.ndc_y = ny; r.tex_u = u; r.tex_v = v; r.clipped = clip;
    sprite_table.push_back(r);
  endfunction

  function automatic sprite_beat_t random_sprite();
    sprite_beat_t sp;
    sp = sprite_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(99) < 60) begin
      // plausible on-screen sprite
      sp.pos_x   = $urandom_range(0, 16 * 2000);
      sp.pos_y   = $urandom_range(0, 16 * 1200);
      sp.scale_x = $signed($urandom_range(0, 1024)) - 512;
      sp.scale_y = $signed($urandom_range(0, 1024)) - 512;
      sp.tex_pos_x  = $urandom_range(0, 512);
      sp.tex_pos_y  = $urandom_range(0, 512);
      sp.tex_size_x = $urandom_range(0, 256);
      sp.tex_size_y = $urandom_range(0, 256);
      sp.pivot_x = $signed($urandom_range(0, 8192)) - 2048;
      sp.pivot_y = $signed($urandom_range(0, 8192)) - 2048;
    end
    return sp;
  endfunction

  task automatic send_sprite(sprite_row_t r);
    vertex_t vx;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = r.sp;
    do @(posedge clk_i); while (!s_axis_tready);
    sprites_sent++;
    if (r.typed) begin
      for (int k = 0; k < 4; k++) begin
        vx.corner = k[1:0]; vx.ndc_x = r.ndc_x; vx.ndc_y = r.ndc_y;
        vx.tex_u = r.tex_u; vx.tex_v = r.tex_v; vx.clipped = r.clipped;
        vx.last = (k[1:0] == CORNER_BR);
        pending_vertices.push_back(vx);
      end
    end else begin
      predict_vertices(r.sp);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_VIEWPORT_W: vp_w = val;
      REG_VIEWPORT_H: vp_h = val;
      REG_TEXTURE_W:  tx_w = val;
      default:        tx_h = val;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_sizes(int w, int h, int tw, int th);
    drain();
    write_reg(REG_VIEWPORT_W, w);
    write_reg(REG_VIEWPORT_H, h);
    write_reg(REG_TEXTURE_W, tw);
    write_reg(REG_TEXTURE_H, th);
  endtask

  task automatic random_burst(int count);
    sprite_row_t r;
    r.typed = 0;
    for (int i = 0; i < count; i++) begin
      r.sp = random_sprite();
      send_sprite(r);
      if (i == count / 2 && $urandom_range(1)) drain();
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected vertex beat data=%h user=%h", $time, m_axis_tdata,
                 m_axis_tuser);
        mismatches++;
      end else begin
        e = pending_vertices.pop_front();
        if (m_axis_tdata !== {e.tex_v, e.tex_u, e.ndc_y, e.ndc_x} ||
            m_axis_tuser !== {e.clipped, e.corner} || m_axis_tlast !== e.last) begin
          $display("%0t: vertex mismatch expected corner=%0d x=%h y=%h u=%h v=%h clip=%b last=%b",
                   $time, e.corner, e.ndc_x, e.ndc_y, e.tex_u, e.tex_v, e.clipped, e.last);
          $display("%0t:                   actual corner=%0d x=%h y=%h u=%h v=%h clip=%b last=%b",
                   $time, m_axis_tuser[1:0], m_axis_tdata[15:0], m_axis_tdata[31:16],
                   m_axis_tdata[47:32], m_axis_tdata[63:48], m_axis_tuser[2], m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    add_row(mk_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, -4096, 4096, 0, 0, 0);
    add_row(mk_sprite(524287, -524288, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 32767, 32767, 0, 0, 1);
    add_row(mk_sprite(0, 0, 0, 0, 0, 8191, 8191, 0, 0, 0, 0), 1, -4096, 4096, 65535, 65535, 1);
    add_row(mk_sprite(-524288, 524287, 0, 0, 65535, 0, 0, 0, 0, 0, 0), 1, -32768, -32768,
            0, 0, 1);
    add_row(mk_sprite(10240, 5760, 256, 256, 0, 0, 0, 64, 32, 0, 0));
    add_row(mk_sprite(10240, 5760, 256, 256, 16384, 0, 0, 64, 32, 512, 256));
    add_row(mk_sprite(10240, 5760, 256, 256, 32768, 0, 0, 64, 32, 512, 256));
    add_row(mk_sprite(10240, 5760, 256, 256, 49152, 0, 0, 64, 32, 512, 256));
    add_row(mk_sprite(10240, 5760, 256, 256, 65535, 0, 0, 64, 32, 512, 256));
    add_row(mk_sprite(10240, 5760, 256, 256, 8191, 0, 0, 64, 32, 512, 256));
    add_row(mk_sprite(10240, 5760, 32767, 32767, 0, 0, 0, 8191, 8191, 0, 0));
    add_row(mk_sprite(10240, 5760, -32768, -32768, 4096, 0, 0, 8191, 8191, 0, 0));
    add_row(mk_sprite(10240, 5760, -256, 256, 0, 100, 100, 64, 64, 0, 0));
    add_row(mk_sprite(0, 0, 256, -256, 1000, 0, 0, 8191, 8191, 131071, -131072));
    add_row(mk_sprite(0, 0, 32767, -32768, 30000, 8191, 8191, 8191, 8191, -131072, 131071));
    add_row(mk_sprite(1000, 1000, 512, 512, 20000, 5, 7, 0, 0, 16, 16));
    add_row(mk_sprite(-1, -1, -1, -1, 65535, 8191, 0, 0, 8191, -1, -1));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (sprite_table[i]) send_sprite(sprite_table[i]);
    set_sizes(1, 1, 8192, 8192);
    foreach (sprite_table[i]) if (!sprite_table[i].typed) send_sprite(sprite_table[i]);

    send_idle_pct = 29; recv_idle_pct = 78;
    set_sizes(1280, 720, 256, 256);
    random_burst(60);
    drain();
    set_sizes(0, 0, 0, 0);
    random_burst(40);

    send_idle_pct = 78; recv_idle_pct = 29;
    set_sizes(16383, 16383, 16383, 16383);
    random_burst(60);
    set_sizes(8192, 1, 1, 8192);
    random_burst(40);

    send_idle_pct = 0; recv_idle_pct = 0;
    for (int p = 0; p < 3; p++) begin
      set_sizes($urandom_range(1, 8192), $urandom_range(1, 8192),
                $urandom_range(1, 8192), $urandom_range(1, 8192));
      random_burst(40);
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("covered %0d sprites, %0d vertex beats, %0d register writes", sprites_sent,
             vertices_seen, cfg_writes);
    $display("sizes swept from zero and one up to 16383, with both sides stalling");
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
